[rtl/register_alu_instruction_executor_defines.svh]
// Assertion macros shared by the executor modules.
`ifndef REGISTER_ALU_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define REGISTER_ALU_INSTRUCTION_EXECUTOR_DEFINES_SVH

// Clocked check that is switched off while reset is held.
`define RAIE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define RAIE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/raie_pkg.sv]
// Types and constants of the register ALU instruction executor.
`default_nettype none
package raie_pkg;

  // The register file has a fixed count of sixteen entries.
  localparam int REG_COUNT = 16;
  localparam int REG_IDX_W = 4;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_VALUE_W = 32;
  localparam int OUT_TDATA_W = 40;

  // Opcodes taken from the top nibble of the first instruction byte.
  localparam logic [3:0] OP_HALT = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_AND  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_MUL  = 4'd4;
  localparam logic [3:0] OP_SUB  = 4'd5;
  localparam logic [3:0] OP_OR   = 4'd6;
  localparam logic [3:0] OP_MOVE = 4'd11;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_WRITE
  } state_t;

  // Request to the shared multiply and divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

  // Status returned by the multiply and divide unit.
  typedef struct packed {
    logic busy;
    logic done;
  } md_sts_t;

endpackage
`default_nettype wire

[rtl/raie_ram.sv]
// Generic RAM with one write port and two registered read ports.
`default_nettype none
module raie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and both reads share the clock; read data is registered and appears in the cycle after the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

[rtl/raie_muldiv.sv]
// Shared iterative unit: shift-add multiply and restoring signed divide.
`default_nettype none
`include "register_alu_instruction_executor_defines.svh"
module raie_muldiv #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire raie_pkg::md_req_t     req,
  input  wire logic [DATA_WIDTH-1:0] a,
  input  wire logic [DATA_WIDTH-1:0] b,
  output raie_pkg::md_sts_t          sts,
  output logic      [DATA_WIDTH-1:0] result
);

  localparam int CNT_W = $clog2(DATA_WIDTH);

  logic             busy;
  logic             done_q;
  logic             div_q;
  logic             neg_q;
  logic [CNT_W-1:0] cnt;
  // acc: product or partial remainder; lo: multiplier or quotient;
  // hi: multiplicand or divisor magnitude.
  logic [DATA_WIDTH:0]   acc;
  logic [DATA_WIDTH-1:0] lo;
  logic [DATA_WIDTH-1:0] hi;

  logic [DATA_WIDTH-1:0] a_mag;
  logic [DATA_WIDTH-1:0] b_mag;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH+1:0] rem_diff;
  logic [DATA_WIDTH-1:0] prod_add;
  logic                  last;

  // Operand magnitudes for the signed divide.
  assign a_mag = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
  assign b_mag = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;

  // One bit of the divide: shift in the next dividend bit and try a subtract.
  assign rem_sh   = {acc[DATA_WIDTH-1:0], lo[DATA_WIDTH-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, hi};

  // One bit of the multiply.
  assign prod_add = acc[DATA_WIDTH-1:0] + (lo[0] ? hi : '0);

  assign last = (cnt == CNT_W'(DATA_WIDTH - 1));

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_q <= 1'b0;
      cnt    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy   <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      div_q <= req.is_div;
      neg_q <= req.is_div & (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]);
      acc   <= '0;
      lo    <= req.is_div ? a_mag : b;
      hi    <= req.is_div ? b_mag : a;
    end else if (busy) begin
      if (div_q) begin
        if (rem_diff[DATA_WIDTH+1]) begin
          acc <= rem_sh;
        end else begin
          acc <= rem_diff[DATA_WIDTH:0];
        end
        lo <= {lo[DATA_WIDTH-2:0], ~rem_diff[DATA_WIDTH+1]};
      end else begin
        acc <= {1'b0, prod_add};
        lo  <= lo >> 1;
        hi  <= hi << 1;
      end
    end
  end

  // The quotient takes the sign fix on the way out.
  always_comb begin
    if (div_q) begin
      result = neg_q ? (~lo + 1'b1) : lo;
    end else begin
      result = acc[DATA_WIDTH-1:0];
    end
  end

  assign sts.busy = busy;
  assign sts.done = done_q;

  `RAIE_ASSERT(a_start_when_free, req.start |-> !busy, "muldiv started while busy")
  `RAIE_ASSERT(a_done_single, done_q |=> !done_q, "muldiv done lasted two cycles")
  `RAIE_ASSERT(a_done_after_busy, done_q |-> $past(busy), "muldiv done without a run")

endmodule
`default_nettype wire

[rtl/register_alu_instruction_executor.sv]
// Top level of the register ALU instruction executor.
//
// Channel  Dir  Width  Words carried
// s_*      in   16     one two-byte instruction per word
// m_*      out  40     one result per instruction
//
// Words are accepted only in the idle step, one instruction at a time. Add, and,
// subtract, or, move, halt and no-op words go from the execute step straight to
// the write step, as do a divide by zero and any word after a halt; multiply and
// divide with a nonzero divisor wait between them for the bit-serial loop of the
// shared multiply and divide unit. The register file sits in a RAM read at
// acceptance; a per-entry valid bit makes every register read as zero after
// reset, so no clearing pass runs. A stalled result holds the sequencer in its
// write step until taken.
`default_nettype none
`include "register_alu_instruction_executor_defines.svh"
module register_alu_instruction_executor #(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // first_byte [7:0], second_byte [15:8]
  input  wire logic [raie_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // wrote [0], dest_index [4:1], write_value [36:5], halted [37],
  // div_by_zero [38], zero [39]
  output logic      [raie_pkg::OUT_TDATA_W-1:0] m_tdata
);

  localparam int IW = raie_pkg::REG_IDX_W;

  raie_pkg::state_t state;
  raie_pkg::state_t state_next;

  logic                         halt_state;
  logic [raie_pkg::REG_COUNT-1:0] vld;

  // Captured instruction fields.
  logic [3:0]    op_q;
  logic [IW-1:0] ra_q;
  logic [IW-1:0] rd_q;
  logic [7:0]    imm_q;

  // Result being built.
  logic                  wr_q;
  logic [IW-1:0]         dest_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic                  dz_q;

  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic                  ram_we;
  logic [IW-1:0]         rb_in;
  logic [DATA_WIDTH-1:0] rd_a;
  logic [DATA_WIDTH-1:0] rd_b;
  logic [DATA_WIDTH-1:0] x;
  logic [DATA_WIDTH-1:0] y;
  logic [DATA_WIDTH-1:0] alu;
  logic [IW-1:0]         rb_q;

  raie_pkg::md_req_t     md_req;
  raie_pkg::md_sts_t     md_sts;
  logic [DATA_WIDTH-1:0] md_result;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign rb_in    = s_tdata[15:12];

  // Register file storage.
  raie_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (raie_pkg::REG_COUNT)
  ) u_regs (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (dest_q),
    .wdata   (val_q),
    .raddr_a (s_tdata[3:0]),
    .raddr_b (rb_in),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Shared multiply and divide unit.
  raie_muldiv #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .req    (md_req),
    .a      (x),
    .b      (y),
    .sts    (md_sts),
    .result (md_result)
  );

  // Registers never written since reset read as zero.
  assign x = vld[ra_q] ? rd_a : '0;
  assign y = vld[rb_q] ? rd_b : '0;

  // Combinational operations that need no multiply and divide unit.
  always_comb begin
    case (op_q)
      raie_pkg::OP_ADD:  alu = x + y;
      raie_pkg::OP_AND:  alu = x & y;
      raie_pkg::OP_SUB:  alu = x - y;
      raie_pkg::OP_OR:   alu = x | y;
      raie_pkg::OP_MOVE: alu = DATA_WIDTH'(imm_q);
      default:           alu = '0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      raie_pkg::S_IDLE: begin
        if (accept) state_next = raie_pkg::S_EXEC;
      end
      raie_pkg::S_EXEC: begin
        state_next = md_req.start ? raie_pkg::S_WAIT : raie_pkg::S_WRITE;
      end
      raie_pkg::S_WAIT: begin
        if (md_sts.done) state_next = raie_pkg::S_WRITE;
      end
      raie_pkg::S_WRITE: begin
        if (out_free) state_next = raie_pkg::S_IDLE;
      end
      default: state_next = raie_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready      = 1'b0;
    md_req.start  = 1'b0;
    md_req.is_div = (op_q == raie_pkg::OP_DIV);
    out_load      = 1'b0;
    unique case (state)
      raie_pkg::S_IDLE: begin
        s_tready = 1'b1;
      end
      raie_pkg::S_EXEC: begin
        md_req.start = !halt_state &&
                       ((op_q == raie_pkg::OP_MUL) ||
                        ((op_q == raie_pkg::OP_DIV) && (y != '0)));
      end
      raie_pkg::S_WAIT: begin
      end
      raie_pkg::S_WRITE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  assign ram_we = out_load && wr_q;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= raie_pkg::S_IDLE;
      halt_state <= 1'b0;
      vld        <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == raie_pkg::S_EXEC) && !halt_state && (op_q == raie_pkg::OP_HALT)) begin
        halt_state <= 1'b1;
      end
      if (ram_we) begin
        vld[dest_q] <= 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Instruction capture and result building.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= s_tdata[7:4];
      ra_q  <= s_tdata[3:0];
      rb_q  <= rb_in;
      rd_q  <= s_tdata[11:8];
      imm_q <= s_tdata[15:8];
    end
    if (state == raie_pkg::S_EXEC) begin
      wr_q   <= 1'b0;
      dest_q <= '0;
      val_q  <= '0;
      dz_q   <= 1'b0;
      if (!halt_state) begin
        unique case (op_q) inside
          raie_pkg::OP_ADD, raie_pkg::OP_AND, raie_pkg::OP_SUB, raie_pkg::OP_OR,
          raie_pkg::OP_MUL: begin
            wr_q   <= 1'b1;
            dest_q <= rd_q;
            val_q  <= alu;
          end
          raie_pkg::OP_DIV: begin
            wr_q   <= 1'b1;
            dest_q <= rd_q;
            dz_q   <= (y == '0);
          end
          raie_pkg::OP_MOVE: begin
            wr_q   <= 1'b1;
            dest_q <= ra_q;
            val_q  <= alu;
          end
          default: begin
          end
        endcase
      end
    end
    if ((state == raie_pkg::S_WAIT) && md_sts.done) begin
      val_q <= md_result;
    end
    if (out_load) begin
      m_tdata <= {1'b0, dz_q, halt_state, raie_pkg::OUT_VALUE_W'(val_q), dest_q, wr_q};
    end
  end

  `RAIE_ASSERT(a_write_with_result, ram_we |-> out_load, "register write without a result")
  `RAIE_ASSERT(a_no_write_halted, halt_state |-> !ram_we, "register written after halt")
  `RAIE_ASSERT(a_done_in_wait, md_sts.done |-> (state == raie_pkg::S_WAIT),
               "muldiv finished outside the wait step")
  `RAIE_ASSERT(a_dz_writes_zero, (out_load && dz_q) |-> (wr_q && (val_q == '0)),
               "divide by zero did not write zero")

endmodule
`default_nettype wire

[dv/raie_checker.sv]
// Checker that predicts and compares every result word of the instruction executor.
`default_nettype none
module raie_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  input  wire logic                             s_tready,
  input  wire logic [raie_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  wire logic                             m_tvalid,
  input  wire logic                             m_tready,
  input  wire logic [raie_pkg::OUT_TDATA_W-1:0] m_tdata,
  output int                                    fail_count,
  output int                                    pending,
  output int                                    words_checked,
  output int                                    zero_divides
);

  // Mismatch lines beyond this many are counted but not printed.
  localparam int MAX_REPORTS = 40;
  localparam int VALUE_W     = raie_pkg::OUT_VALUE_W;

  // One predicted result word, one field per member.
  typedef struct packed {
    logic                           wrote;
    logic [raie_pkg::REG_IDX_W-1:0] dest;
    logic [VALUE_W-1:0]             value;
    logic                           halted;
    logic                           div_zero;
  } outcome_t;

  outcome_t           outcome_q[$];
  logic [VALUE_W-1:0] reg_shadow [raie_pkg::REG_COUNT];
  logic               halted_shadow;

  // Signed quotient truncated toward zero; the most negative value over -1 wraps.
  function automatic logic [VALUE_W-1:0] quotient_trunc(
    input logic [VALUE_W-1:0] num,
    input logic [VALUE_W-1:0] den
  );
    logic [VALUE_W-1:0] mag_num;
    logic [VALUE_W-1:0] mag_den;
    logic [VALUE_W-1:0] quo;
    mag_num = num[VALUE_W-1] ? -num : num;
    mag_den = den[VALUE_W-1] ? -den : den;
    quo = mag_num / mag_den;
    return (num[VALUE_W-1] ^ den[VALUE_W-1]) ? -quo : quo;
  endfunction

  // Executes one instruction word on the shadow registers and returns its result.
  task automatic execute_instr(input logic [raie_pkg::IN_TDATA_W-1:0] word,
                               output outcome_t res);
    logic [3:0]         op;
    logic [3:0]         ra;
    logic [3:0]         rb;
    logic [7:0]         imm;
    logic [VALUE_W-1:0] x;
    logic [VALUE_W-1:0] y;
    op  = word[7:4];
    ra  = word[3:0];
    rb  = word[15:12];
    imm = word[15:8];
    x   = reg_shadow[ra];
    y   = reg_shadow[rb];
    res = '0;
    if (!halted_shadow) begin
      res.wrote = 1'b1;
      res.dest  = word[11:8];
      case (op)
        raie_pkg::OP_HALT: begin
          halted_shadow = 1'b1;
          res.wrote     = 1'b0;
        end
        raie_pkg::OP_ADD: res.value = x + y;
        raie_pkg::OP_AND: res.value = x & y;
        raie_pkg::OP_DIV: begin
          if (y == '0) begin
            res.div_zero = 1'b1;
            res.value    = '0;
          end else begin
            res.value = quotient_trunc(x, y);
          end
        end
        raie_pkg::OP_MUL: res.value = x * y;
        raie_pkg::OP_SUB: res.value = x - y;
        raie_pkg::OP_OR:  res.value = x | y;
        raie_pkg::OP_MOVE: begin
          res.dest  = ra;
          res.value = VALUE_W'(imm);
        end
        default: res.wrote = 1'b0;
      endcase
      if (res.wrote) begin
        reg_shadow[res.dest] = res.value;
      end else begin
        res.dest  = '0;
        res.value = '0;
      end
    end
    res.halted = halted_shadow;
  endtask

  // Counts a mismatch and prints one line for it while under the report limit.
  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] want,
                                 input logic [VALUE_W-1:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("mismatch on result word %0d: %s expected 0x%08h, got 0x%08h",
               words_checked, what, want, got);
  endtask

  // Compare the result word first, then predict the accepted instruction word.
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst) begin
      for (int i = 0; i < raie_pkg::REG_COUNT; i++) reg_shadow[i] = '0;
      halted_shadow = 1'b0;
      outcome_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.wrote    = m_tdata[0];
        got.dest     = m_tdata[4:1];
        got.value    = m_tdata[36:5];
        got.halted   = m_tdata[37];
        got.div_zero = m_tdata[38];
        if (outcome_q.size() == 0) begin
          report_mismatch("word with no instruction pending, low bits", '0, m_tdata[31:0]);
        end else begin
          want = outcome_q.pop_front();
          if (got.wrote !== want.wrote)
            report_mismatch("wrote", VALUE_W'(want.wrote), VALUE_W'(got.wrote));
          if (got.dest !== want.dest)
            report_mismatch("dest_index", VALUE_W'(want.dest), VALUE_W'(got.dest));
          if (got.value !== want.value) report_mismatch("write_value", want.value, got.value);
          if (got.halted !== want.halted)
            report_mismatch("halted", VALUE_W'(want.halted), VALUE_W'(got.halted));
          if (got.div_zero !== want.div_zero)
            report_mismatch("div_by_zero", VALUE_W'(want.div_zero), VALUE_W'(got.div_zero));
          if (m_tdata[39] !== 1'b0) report_mismatch("pad bit", '0, VALUE_W'(m_tdata[39]));
          if (want.div_zero) zero_divides++;
        end
        words_checked++;
      end
      if (s_tvalid && s_tready) begin
        execute_instr(s_tdata, want);
        outcome_q.push_back(want);
      end
    end
    pending = outcome_q.size();
  end

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Testbench top: clock, reset, instruction stimulus, result back-pressure and verdict.
`default_nettype none
module tb_top;

  localparam int CLK_PERIOD   = 4;
  localparam int N_ITEMS      = 1950;
  localparam int N_AFTER_HALT = 15;
  localparam int CALM_TAIL    = 200;
  localparam int CALM_FROM    = 700;
  localparam int CALM_TO      = 900;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 600000;
  localparam int IN_W         = raie_pkg::IN_TDATA_W;
  localparam int OUT_W        = raie_pkg::OUT_TDATA_W;

  // Opcodes the block leaves as no-ops.
  localparam logic [3:0] OP_BRANCH = 4'd7;
  localparam logic [3:0] OP_LOAD   = 4'd8;
  localparam logic [3:0] OP_STORE  = 4'd9;
  localparam logic [3:0] OP_POP    = 4'd10;
  localparam logic [3:0] OP_DUMP   = 4'd12;
  localparam logic [3:0] OP_RSVD_D = 4'd13;
  localparam logic [3:0] OP_RSVD_E = 4'd14;
  localparam logic [3:0] OP_RSVD_F = 4'd15;
  localparam int         N_NOOPS   = 8;
  localparam logic [4*N_NOOPS-1:0] NOOP_OPS = {OP_RSVD_F, OP_RSVD_E, OP_RSVD_D, OP_DUMP,
                                               OP_POP, OP_STORE, OP_LOAD, OP_BRANCH};

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;

  int fail_count;
  int pending;
  int words_checked;
  int zero_divides;
  int sent;
  bit tx_idle_on;
  bit rx_idle_on;

  register_alu_instruction_executor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  raie_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked),
    .zero_divides  (zero_divides)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout after %0d cycles with %0d results outstanding", LIMIT_CYCLES, pending);
    $display("status: fail");
    $finish;
  end

  // Result side: random stall bursts while enabled, otherwise always ready.
  initial begin
    int unsigned stall_left;
    m_tready   = 1'b1;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && rx_idle_on && $urandom_range(0, 5) == 0)
        stall_left = $urandom_range(1, 12);
      if (stall_left != 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offers one instruction word and waits until it is taken.
  task automatic push_instr(input logic [7:0] b0, input logic [7:0] b1);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {b1, b0};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic push_alu(input logic [3:0] op, input logic [3:0] ra, input logic [3:0] rb,
                          input logic [3:0] rd);
    push_instr({op, ra}, {rb, rd});
  endtask

  // Sender gap with junk on the data lines.
  task automatic hold_off(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= IN_W'($urandom);
    end
  endtask

  // Occasional sender gap while idling is enabled.
  task automatic pace();
    if (tx_idle_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 12));
  endtask

  // Holds the sender off until every predicted result has come back.
  task automatic wait_results_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [3:0] alu_op(input int unsigned sel);
    case (sel)
      0:       return raie_pkg::OP_ADD;
      1:       return raie_pkg::OP_AND;
      2:       return raie_pkg::OP_DIV;
      3:       return raie_pkg::OP_MUL;
      4:       return raie_pkg::OP_SUB;
      default: return raie_pkg::OP_OR;
    endcase
  endfunction

  // Stimulus and verdict.
  initial begin
    logic [7:0]  b0;
    logic [7:0]  b1;
    int unsigned pick;
    int          n_random;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    sent       = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;

    // Directed: immediate extremes, divide by zero, divide overflow and truncation.
    push_instr({raie_pkg::OP_MOVE, 4'd1}, 8'hFF);
    pace();
    push_instr({raie_pkg::OP_MOVE, 4'd2}, 8'h00);
    push_alu(raie_pkg::OP_DIV, 4'd1, 4'd2, 4'd3);
    push_instr({raie_pkg::OP_MOVE, 4'd4}, 8'h01);
    pace();
    // Zero minus one gives the all-ones divisor.
    push_alu(raie_pkg::OP_SUB, 4'd2, 4'd4, 4'd5);
    push_instr({raie_pkg::OP_MOVE, 4'd6}, 8'h80);
    push_alu(raie_pkg::OP_MUL, 4'd6, 4'd6, 4'd7);
    pace();
    push_alu(raie_pkg::OP_MUL, 4'd7, 4'd6, 4'd7);
    push_alu(raie_pkg::OP_MUL, 4'd7, 4'd6, 4'd7);
    push_instr({raie_pkg::OP_MOVE, 4'd8}, 8'h08);
    // Builds the most negative value, then divides it by minus one.
    push_alu(raie_pkg::OP_MUL, 4'd7, 4'd8, 4'd9);
    push_alu(raie_pkg::OP_DIV, 4'd9, 4'd5, 4'd10);
    pace();
    push_instr({raie_pkg::OP_MOVE, 4'd11}, 8'h07);
    push_alu(raie_pkg::OP_SUB, 4'd2, 4'd11, 4'd12);
    // Minus seven over eight truncates to zero, not minus one.
    push_alu(raie_pkg::OP_DIV, 4'd12, 4'd8, 4'd14);
    push_alu(raie_pkg::OP_DIV, 4'd9, 4'd8, 4'd13);
    push_alu(raie_pkg::OP_ADD, 4'd5, 4'd5, 4'd15);
    pace();
    push_alu(raie_pkg::OP_ADD, 4'd9, 4'd9, 4'd0);
    push_alu(raie_pkg::OP_AND, 4'd1, 4'd5, 4'd0);
    push_alu(raie_pkg::OP_OR, 4'd9, 4'd1, 4'd3);
    for (int i = 0; i < N_NOOPS; i++) begin
      push_instr({NOOP_OPS[4*i +: 4], 4'(i + 8)}, (i == N_NOOPS - 1) ? 8'hFF : 8'(i * 37));
      pace();
    end

    // Random: mostly register operations and moves, a few no-ops; no halt yet.
    n_random = N_ITEMS - sent - 1 - N_AFTER_HALT;
    for (int i = 0; i < n_random; i++) begin
      tx_idle_on = !(sent >= CALM_FROM && sent < CALM_TO) && sent < N_ITEMS - CALM_TAIL;
      rx_idle_on = tx_idle_on;
      if (i == n_random / 2) wait_results_drained();
      b0   = 8'($urandom_range(0, 255));
      b1   = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 72)
        b0[7:4] = alu_op($urandom_range(0, 5));
      else if (pick < 92)
        b0[7:4] = raie_pkg::OP_MOVE;
      else
        b0[7:4] = NOOP_OPS[4*$urandom_range(0, N_NOOPS - 1) +: 4];
      push_instr(b0, b1);
      pace();
    end

    // Halt, then words of any kind that must all be ignored.
    wait_results_drained();
    push_instr({raie_pkg::OP_HALT, 4'($urandom_range(0, 15))}, 8'($urandom_range(0, 255)));
    for (int i = 0; i < N_AFTER_HALT; i++)
      push_instr(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run sent %0d instruction words: moves, all six register operations, no-ops,",
             sent);
    $display("divide corner cases (%0d by zero) and a halt; %0d result words checked",
             zero_divides, words_checked);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

[register_alu_instruction_executor.f]
+incdir+rtl
rtl/raie_pkg.sv
rtl/raie_ram.sv
rtl/raie_muldiv.sv
rtl/register_alu_instruction_executor.sv
dv/raie_checker.sv
dv/tb_top.sv
